### src/granule_chain_allocator_assert.svh
`ifndef GRANULE_CHAIN_ALLOCATOR_ASSERT_SVH
`define GRANULE_CHAIN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define GCA_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gca: same-cycle check failed");

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define GCA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gca: next-cycle check failed");

`endif

### src/gca_pkg.sv
package gca_pkg;

    localparam int OP_W      = 2;
    localparam int BYTES_W   = 25;
    localparam int ID_PORT_W = 14;
    localparam int ST_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NEXT  = 2'd3
    } t_opcode;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD      = 2'd2;

    typedef struct packed {
        t_opcode                opcode;
        logic [BYTES_W-1:0]     byte_count;
        logic [ID_PORT_W-1:0]   granule_id;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]        status;
        logic [ID_PORT_W-1:0]   result_id;
        logic [ID_PORT_W-1:0]   free_granules;
    } t_rsp;

    // Which response the datapath builds this cycle, with its state update.
    typedef enum logic [2:0] {
        RSP_NONE,
        RSP_INIT,
        RSP_BAD,
        RSP_SPACE,
        RSP_NEXT,
        RSP_ALLOC,
        RSP_FREE
    } t_rsp_kind;

    typedef struct packed {
        logic       load;
        logic       clr_start;
        logic       clr_wr;
        logic       walk_start;
        logic       rd;
        logic       step;
        t_rsp_kind  rsp;
    } t_dp_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       id_bad;
        logic       zero_req;
        logic       no_space;
        logic       alloc_more;
        logic       free_more;
    } t_dp_sts;

endpackage

### src/gca_ctrl.sv
module gca_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  gca_pkg::t_opcode  i_opcode,
    input  gca_pkg::t_dp_sts  i_sts,
    output logic              o_busy,
    output gca_pkg::t_dp_cmd  o_ctl
);
    import gca_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_RD,
        S_STEP,
        S_FIN
    } t_state;

    t_state  r_state, n_state;
    t_opcode r_op, n_op;
    logic    r_init, n_init;
    t_dp_cmd ctl;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_init  = r_init;
        ctl     = '0;
        ctl.rsp = RSP_NONE;
        case (r_state)
            S_CLEAR: begin
                ctl.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    if (r_init) begin
                        ctl.rsp = RSP_INIT;
                    end
                    n_init  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_op = i_opcode;
                    if (i_opcode == OP_INIT) begin
                        ctl.clr_start = 1'b1;
                        n_init        = 1'b1;
                        n_state       = S_CLEAR;
                    end else begin
                        ctl.load = 1'b1;
                        n_state  = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_op == OP_ALLOC) begin
                    if (i_sts.zero_req) begin
                        ctl.rsp = RSP_BAD;
                        n_state = S_IDLE;
                    end else if (i_sts.no_space) begin
                        ctl.rsp = RSP_SPACE;
                        n_state = S_IDLE;
                    end else begin
                        ctl.walk_start = 1'b1;
                        n_state        = S_RD;
                    end
                end else if (i_sts.id_bad) begin
                    ctl.rsp = RSP_BAD;
                    n_state = S_IDLE;
                end else begin
                    ctl.walk_start = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                ctl.rd  = 1'b1;
                n_state = S_STEP;
            end
            S_STEP: begin
                if (r_op == OP_NEXT) begin
                    ctl.rsp = RSP_NEXT;
                    n_state = S_IDLE;
                end else begin
                    ctl.step = 1'b1;
                    if ((r_op == OP_ALLOC) ? i_sts.alloc_more : i_sts.free_more) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                ctl.rsp = (r_op == OP_ALLOC) ? RSP_ALLOC : RSP_FREE;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_op    <= OP_INIT;
            r_init  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_init  <= n_init;
        end
    end

    assign o_ctl  = ctl;
    assign o_busy = (r_state != S_IDLE);

endmodule

### src/gca_dp.sv
module gca_dp #(
    parameter int GRANULES      = 8192,
    parameter int GRANULE_BYTES = 4080
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gca_pkg::t_cmd     i_cmd,
    input  gca_pkg::t_dp_cmd  i_ctl,
    output gca_pkg::t_dp_sts  o_sts,
    output gca_pkg::t_rsp     o_rsp,
    output logic              o_done
);
    import gca_pkg::*;

`include "granule_chain_allocator_assert.svh"

    localparam int IDX_W  = $clog2(GRANULES);
    localparam int ID_W   = $clog2(GRANULES + 1);
    localparam int CNT_W  = ID_W;
    localparam int GB_W   = $clog2(GRANULE_BYTES + 1);
    localparam int PROD_W = CNT_W + GB_W;
    localparam int CMP_W  = (PROD_W > BYTES_W) ? PROD_W : BYTES_W;

    localparam logic [ID_W-1:0]    NONE_ID  = ID_W'(GRANULES);
    localparam logic [CNT_W-1:0]   FULL_CNT = CNT_W'(GRANULES);
    localparam logic [CNT_W:0]     FULL_SUM = (CNT_W + 1)'(GRANULES);
    localparam logic [BYTES_W-1:0] GB_VAL   = BYTES_W'(GRANULE_BYTES);

    logic [ID_W-1:0]    r_mem [GRANULES];

    t_cmd               r_req;
    logic [ID_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]   r_fc, n_fc;
    logic [ID_W-1:0]    r_cur;
    logic [ID_W-1:0]    r_last;
    logic [ID_W-1:0]    r_rdata;
    logic [CNT_W-1:0]   r_taken;
    logic [BYTES_W-1:0] r_rem;
    logic [IDX_W-1:0]   r_idx;
    logic [PROD_W-1:0]  r_prod;
    t_rsp               r_rsp, n_rsp;
    logic               r_done;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ID_W-1:0]    wr_data;
    logic [CNT_W:0]     free_sum;
    logic               clr_last;
    logic               rdata_ok;

    assign clr_last = (r_idx == IDX_W'(GRANULES - 1));
    assign rdata_ok = (r_rdata < NONE_ID);
    assign free_sum = (CNT_W + 1)'(r_fc) + (CNT_W + 1)'(r_taken);

    // A request has no space when bytes > free_count * granule size or the free list is empty.
    always_comb begin
        o_sts.clr_last   = clr_last;
        o_sts.id_bad     = ({1'b0, r_req.granule_id} >= (ID_PORT_W + 1)'(GRANULES));
        o_sts.zero_req   = (r_req.byte_count == '0);
        o_sts.no_space   = (CMP_W'(r_req.byte_count) > CMP_W'(r_prod)) || (r_head >= NONE_ID);
        o_sts.alloc_more = (r_rem > GB_VAL) && rdata_ok;
        o_sts.free_more  = (((CNT_W + 1)'(r_taken) + (CNT_W + 1)'(1)) < FULL_SUM) && rdata_ok;
    end

    always_comb begin
        n_head  = r_head;
        n_fc    = r_fc;
        n_rsp   = r_rsp;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = ID_W'(r_idx) + ID_W'(1);
        if (i_ctl.clr_wr) begin
            wr_en = 1'b1;
            if (clr_last) begin
                n_head = '0;
                n_fc   = FULL_CNT;
            end
        end
        case (i_ctl.rsp)
            RSP_INIT: begin
                n_rsp.status    = ST_OK;
                n_rsp.result_id = ID_PORT_W'(NONE_ID);
            end
            RSP_BAD: begin
                n_rsp.status    = ST_BAD;
                n_rsp.result_id = ID_PORT_W'(NONE_ID);
            end
            RSP_SPACE: begin
                n_rsp.status    = ST_NO_SPACE;
                n_rsp.result_id = ID_PORT_W'(NONE_ID);
            end
            RSP_NEXT: begin
                n_rsp.status    = ST_OK;
                n_rsp.result_id = ID_PORT_W'(r_rdata);
            end
            RSP_ALLOC: begin
                wr_en           = 1'b1;
                wr_addr         = r_last[IDX_W-1:0];
                wr_data         = NONE_ID;
                n_head          = (r_cur < NONE_ID) ? r_cur : NONE_ID;
                n_fc            = r_fc - r_taken;
                n_rsp.status    = ST_OK;
                n_rsp.result_id = ID_PORT_W'(r_head);
            end
            RSP_FREE: begin
                wr_en           = 1'b1;
                wr_addr         = r_last[IDX_W-1:0];
                wr_data         = r_head;
                n_head          = ID_W'(r_req.granule_id);
                n_fc            = (free_sum > FULL_SUM) ? FULL_CNT : CNT_W'(free_sum);
                n_rsp.status    = ST_OK;
                n_rsp.result_id = ID_PORT_W'(NONE_ID);
            end
            default: begin
            end
        endcase
        n_rsp.free_granules = ID_PORT_W'(n_fc);
    end

    // Link memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[r_cur[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_head <= '0;
            r_fc   <= FULL_CNT;
            r_done <= 1'b0;
        end else begin
            if (i_ctl.clr_start) begin
                r_idx <= '0;
            end else if (i_ctl.clr_wr) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            r_head <= n_head;
            r_fc   <= n_fc;
            r_done <= (i_ctl.rsp != RSP_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_fc) * PROD_W'(GRANULE_BYTES);
        r_rsp  <= n_rsp;
        if (i_ctl.load) begin
            r_req <= i_cmd;
        end
        if (i_ctl.walk_start) begin
            r_cur   <= (r_req.opcode == OP_ALLOC) ? r_head : ID_W'(r_req.granule_id);
            r_taken <= '0;
            r_rem   <= r_req.byte_count;
        end else if (i_ctl.step) begin
            r_last  <= r_cur;
            r_cur   <= r_rdata;
            r_taken <= r_taken + CNT_W'(1);
            r_rem   <= r_rem - GB_VAL;
        end
    end

    assign o_rsp  = r_rsp;
    assign o_done = r_done;

    `GCA_ASSERT_IMPLIES(a_fc_range, 1'b1, r_fc <= FULL_CNT)

endmodule

### src/granule_chain_allocator.sv
// Linked free-list allocator over a pool of GRANULES granules of GRANULE_BYTES
// bytes each. An operation transfers in when start is high while busy is low,
// and its single result appears on o_rsp for exactly one cycle with o_done
// high; the receiver cannot stall it, so it must take every result as it comes.
// Busy drops in the cycle the result is shown, so the next operation can start
// then. After the accepting edge, a rejected request (zero bytes, bad id, too
// little space) is answered from the check state, a link read passes through
// the check, read and step states, and an allocate or a free passes the check
// state, then for each granule it visits a read of the link memory and a step
// that follows the link, and then the finish state. Init rewrites every link
// entry, one per cycle. After reset the same clearing pass runs with busy high
// before the first transfer is taken; it produces no result. Identifiers on the
// ports are 14 bits wide, and the value GRANULES, cut to 14 bits, stands for
// "no granule".
module granule_chain_allocator #(
    parameter int GRANULES      = 8192,
    parameter int GRANULE_BYTES = 4080
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  gca_pkg::t_cmd  i_cmd,
    output logic           busy,
    output gca_pkg::t_rsp  o_rsp,
    output logic           o_done
);
    import gca_pkg::*;

`include "granule_chain_allocator_assert.svh"

    // Port encoding of "no granule".
    localparam logic [ID_PORT_W-1:0] NO_ID = ID_PORT_W'(GRANULES);

    // Commands from the controller and status back from the datapath.
    t_dp_cmd ctl;
    t_dp_sts sts;

    // The controller sequences the walk: check, then read and follow links.
    gca_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_cmd.opcode),
        .i_sts    (sts),
        .o_busy   (busy),
        .o_ctl    (ctl)
    );

    // The datapath holds the link memory, the free-list head and count,
    // the walk registers and the result register.
    gca_dp #(
        .GRANULES      (GRANULES),
        .GRANULE_BYTES (GRANULE_BYTES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_rsp   (o_rsp),
        .o_done  (o_done)
    );

    // A result is shown only once the block is ready for the next transfer.
    `GCA_ASSERT_IMPLIES(a_done_ready, o_done, !busy)
    // Every accepted operation keeps the block busy in the following cycle.
    `GCA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // Error results never carry a granule identifier.
    `GCA_ASSERT_IMPLIES(a_err_none, o_done && (o_rsp.status != ST_OK), o_rsp.result_id == NO_ID)

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the granule chain allocator.
//
// Every command that transfers in (start high while busy is low) is run at
// once through a behavioral copy of the pool: a link table, the free list
// head and the free granule count. The response that copy produces is queued.
// A separate process takes every o_done strobe and compares the response
// field by field with the oldest queued one. The block cannot hold a response
// back, so the only flow control on the result side is the strobe itself.
module testbench;
    import gca_pkg::*;

    localparam int GRANULES      = 8192;
    localparam int GRANULE_BYTES = 4080;
    localparam logic [ID_PORT_W-1:0] NONE_ID = ID_PORT_W'(GRANULES);

    // The longest single operation walks the whole pool.
    localparam int WALK_CYCLES  = 2 * GRANULES + 8;
    localparam int DRAIN_LIMIT  = 4 * GRANULES + 64;
    localparam int EPISODES     = 8;
    localparam int EPISODE_ITEMS = 100;

    // Stimulus side. Every input has a known value from time zero.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_cmd i_cmd   = '0;
    logic busy;
    t_rsp o_rsp;
    logic o_done;

    // Chance, in percent, that the sender extends its idle gap before a command.
    int unsigned idle_pct = 0;
    int unsigned mismatches = 0;

    // Behavioral copy of the pool state.
    logic [ID_PORT_W-1:0] pool_link [GRANULES];
    int unsigned          pool_head;
    int unsigned          pool_count;

    // Responses computed for accepted commands, oldest first.
    t_rsp awaited_rsps [$];

    granule_chain_allocator #(
        .GRANULES      (GRANULES),
        .GRANULE_BYTES (GRANULE_BYTES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_rsp   (o_rsp),
        .o_done  (o_done)
    );

    always #2 i_clk = ~i_clk;

    // Put the pool back in index order: every granule links to the next one,
    // the last one ends the list, and the whole pool is free.
    function automatic void pool_rebuild();
        for (int i = 0; i < GRANULES; i++) begin
            pool_link[i] = (i + 1 < GRANULES) ? ID_PORT_W'(i + 1) : NONE_ID;
        end
        pool_head  = 0;
        pool_count = GRANULES;
    endfunction

    // Apply one command to the pool copy and return the response it gives.
    function automatic t_rsp pool_apply(t_cmd cmd);
        t_rsp        rsp;
        int unsigned bytes;
        int unsigned id;
        int unsigned needed;
        int unsigned taken;
        int unsigned steps;
        int unsigned cur;
        int unsigned last;
        int unsigned head;
        rsp.status    = ST_OK;
        rsp.result_id = NONE_ID;
        bytes = 32'(cmd.byte_count);
        id    = 32'(cmd.granule_id);
        case (cmd.opcode)
            OP_INIT: begin
                pool_rebuild();
            end
            OP_ALLOC: begin
                if (bytes == 0) begin
                    rsp.status = ST_BAD;
                end else begin
                    needed = (bytes + GRANULE_BYTES - 1) / GRANULE_BYTES;
                    if (needed > pool_count || pool_head >= GRANULES) begin
                        rsp.status = ST_NO_SPACE;
                    end else begin
                        // Take granules from the head until enough are taken
                        // or the list ends early; a short list keeps what it
                        // could hand out and leaves the free list empty.
                        head  = pool_head;
                        cur   = head;
                        last  = head;
                        taken = 0;
                        while (taken < needed && cur < GRANULES) begin
                            last = cur;
                            taken++;
                            cur = 32'(pool_link[cur]);
                        end
                        pool_link[last] = NONE_ID;
                        pool_head  = (cur < GRANULES) ? cur : GRANULES;
                        pool_count = pool_count - taken;
                        rsp.result_id = ID_PORT_W'(head);
                    end
                end
            end
            OP_FREE: begin
                if (id >= GRANULES) begin
                    rsp.status = ST_BAD;
                end else begin
                    // The walk is bounded by the pool size, so a cyclic chain
                    // stops after GRANULES visits.
                    cur   = id;
                    last  = id;
                    steps = 0;
                    while (cur < GRANULES && steps < GRANULES) begin
                        last = cur;
                        steps++;
                        cur = 32'(pool_link[cur]);
                    end
                    pool_link[last] = ID_PORT_W'(pool_head);
                    pool_head  = id;
                    pool_count = pool_count + steps;
                    if (pool_count > GRANULES) begin
                        pool_count = GRANULES;
                    end
                end
            end
            OP_NEXT: begin
                if (id >= GRANULES) begin
                    rsp.status = ST_BAD;
                end else begin
                    rsp.result_id = pool_link[id];
                end
            end
            default: begin
            end
        endcase
        rsp.free_granules = ID_PORT_W'(pool_count);
        return rsp;
    endfunction

    function automatic t_cmd make_cmd(t_opcode op, int unsigned bytes, int unsigned id);
        t_cmd cmd;
        cmd.opcode     = op;
        cmd.byte_count = BYTES_W'(bytes);
        cmd.granule_id = ID_PORT_W'(id);
        return cmd;
    endfunction

    // Send one command. The caller is always at a falling edge. Start either
    // stays high straight into the next command or drops for a random number
    // of whole cycles first, so it never falls and rises in one time step.
    // The command is taken at the first rising edge that sees busy low.
    task automatic issue(input t_cmd cmd, output t_rsp rsp);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        rsp = pool_apply(cmd);
        awaited_rsps.push_back(rsp);
        @(negedge i_clk);
    endtask

    task automatic send(input t_opcode op, input int unsigned bytes, input int unsigned id);
        t_rsp rsp;
        issue(make_cmd(op, bytes, id), rsp);
    endtask

    function automatic void check_field(string name, int unsigned exp_val,
                                        int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // Result side: the strobe lasts one cycle, so every rising edge with
    // o_done high is one response transfer.
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_done === 1'b1) begin
            if (awaited_rsps.size() == 0) begin
                $display("%0t ns: response expected none, actual status %0d id %0d free %0d",
                         $time, o_rsp.status, o_rsp.result_id, o_rsp.free_granules);
                mismatches++;
            end else begin
                exp_rsp = awaited_rsps.pop_front();
                check_field("status", 32'(exp_rsp.status), 32'(o_rsp.status));
                check_field("result_id", 32'(exp_rsp.result_id), 32'(o_rsp.result_id));
                check_field("free_granules", 32'(exp_rsp.free_granules),
                            32'(o_rsp.free_granules));
            end
        end
    end

    // Pool as it comes out of reset: links in index order, and the requests
    // that are turned away without touching the pool.
    task automatic test_reset_pool();
        send(OP_NEXT, 0, 0);
        send(OP_NEXT, 0, GRANULES - 1);
        send(OP_ALLOC, 0, 0);
        send(OP_NEXT, 0, GRANULES);
        send(OP_FREE, 0, 2 ** ID_PORT_W - 1);
    endtask

    // Small chains: one granule exactly, one byte over a granule, reading a
    // link inside a chain, freeing in both orders, and a request larger
    // than the whole pool with every byte count bit set.
    task automatic test_chain_ops();
        send(OP_ALLOC, 1, 0);
        send(OP_ALLOC, GRANULE_BYTES, 0);
        send(OP_ALLOC, GRANULE_BYTES + 1, 0);
        send(OP_NEXT, 0, 2);
        send(OP_FREE, 0, 2);
        send(OP_FREE, 0, 0);
        send(OP_ALLOC, 2 ** BYTES_W - 1, 0);
    endtask

    // Rebuild the pool, hand out all of it in one chain, and check that even
    // a one-byte request is then refused.
    task automatic test_full_pool();
        send(OP_INIT, 0, 0);
        send(OP_ALLOC, GRANULES * GRANULE_BYTES, 0);
        send(OP_ALLOC, 1, 0);
        send(OP_NEXT, 0, GRANULES - 1);
    endtask

    // Starting from an empty free list, free two overlapping tails so the
    // free list becomes a three-granule loop, then free into that loop so the
    // walk runs for the whole pool and the count saturates. Two allocations
    // follow: the first cuts the loop, the second runs off the end of the
    // now too short list and gets only part of what it asked for. After that
    // the free list is empty while the count is not, and a request is refused.
    task automatic test_damaged_lists();
        send(OP_FREE, 0, GRANULES - 3);
        send(OP_FREE, 0, GRANULES - 2);
        send(OP_FREE, 0, GRANULES - 3);
        send(OP_ALLOC, GRANULE_BYTES + 1, 0);
        send(OP_ALLOC, GRANULE_BYTES + 1, 0);
        send(OP_ALLOC, 1, 0);
        send(OP_INIT, 0, 0);
    endtask

    // Random traffic in episodes, each opening with an init so that damage
    // from stray frees stays contained. Most commands are well formed:
    // allocations of a few granules, frees of chains handed out earlier and
    // link reads that follow those chains. The rest are zero or oversized
    // requests, out-of-range ids, and now and then a free or read of any
    // granule at all, which can loop or overlap the free list.
    task automatic test_random_traffic();
        int unsigned live_heads [$];
        int unsigned probe_id;
        int unsigned pick;
        int unsigned idx;
        int unsigned bytes;
        int unsigned id;
        t_rsp        rsp;
        for (int ep = 0; ep < EPISODES; ep++) begin
            case (ep % 3)
                0: idle_pct = 0;
                1: idle_pct = 76;
                default: idle_pct = 7;
            endcase
            live_heads.delete();
            probe_id = GRANULES;
            issue(make_cmd(OP_INIT, $urandom, $urandom), rsp);
            for (int n = 0; n < EPISODE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick >= 40 && pick < 70 && live_heads.size() != 0) begin
                    idx = $urandom_range(0, live_heads.size() - 1);
                    id  = live_heads[idx];
                    live_heads.delete(idx);
                    issue(make_cmd(OP_FREE, $urandom, id), rsp);
                end else if (pick < 70) begin
                    case ($urandom_range(0, 9))
                        0:       bytes = $urandom_range(1, 6) * GRANULE_BYTES;
                        1:       bytes = $urandom_range(1, 48 * GRANULE_BYTES);
                        default: bytes = $urandom_range(1, 6 * GRANULE_BYTES);
                    endcase
                    issue(make_cmd(OP_ALLOC, bytes, $urandom), rsp);
                    if (rsp.status == ST_OK) begin
                        live_heads.push_back(32'(rsp.result_id));
                    end
                end else if (pick < 85) begin
                    // Keep following the last link read half the time.
                    if (probe_id < GRANULES && $urandom_range(0, 1) == 1) begin
                        id = probe_id;
                    end else if (live_heads.size() != 0) begin
                        id = live_heads[$urandom_range(0, live_heads.size() - 1)];
                    end else begin
                        id = $urandom_range(0, GRANULES - 1);
                    end
                    issue(make_cmd(OP_NEXT, $urandom, id), rsp);
                    probe_id = 32'(rsp.result_id);
                end else if (pick < 92) begin
                    // Zero bytes, or more than the free count can cover.
                    if ($urandom_range(0, 2) == 0) begin
                        bytes = 0;
                    end else begin
                        bytes = $urandom_range(pool_count * GRANULE_BYTES + 1,
                                               2 ** BYTES_W - 1);
                    end
                    issue(make_cmd(OP_ALLOC, bytes, $urandom), rsp);
                end else if (pick < 97) begin
                    id = $urandom_range(GRANULES, 2 ** ID_PORT_W - 1);
                    if ($urandom_range(0, 1) == 1) begin
                        issue(make_cmd(OP_FREE, $urandom, id), rsp);
                    end else begin
                        issue(make_cmd(OP_NEXT, $urandom, id), rsp);
                    end
                end else begin
                    id = $urandom_range(0, GRANULES - 1);
                    if ($urandom_range(0, 1) == 1) begin
                        // Tracked chains may now overlap the free list, so
                        // they are no longer freed as if they were intact.
                        issue(make_cmd(OP_FREE, $urandom, id), rsp);
                        live_heads.delete();
                    end else begin
                        issue(make_cmd(OP_NEXT, $urandom, id), rsp);
                    end
                end
            end
        end
    endtask

    // Main sequence. Reset is held low from time zero and released at a falling
    // edge. The block then clears its link memory with busy high, which the
    // first transfer simply waits out.
    initial begin
        int unsigned waited;
        pool_rebuild();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_pool();
        test_chain_ops();
        test_full_pool();
        test_damaged_lists();
        test_random_traffic();

        start <= 1'b0;
        waited = 0;
        while (awaited_rsps.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        // Give a stray extra response time to show up.
        repeat (WALK_CYCLES) @(posedge i_clk);
        if (awaited_rsps.size() != 0) begin
            $display("%0t ns: responses expected %0d more, actual 0",
                     $time, awaited_rsps.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hang guard: far beyond even a run in which every command walks the
    // whole pool.
    initial begin
        #250000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
